### sv/server_registration_keepalive_macros.svh
// Assertion helpers for the registration keepalive block.
// Each macro expects clk and rst_n in scope.
`ifndef SERVER_REGISTRATION_KEEPALIVE_MACROS_SVH
`define SERVER_REGISTRATION_KEEPALIVE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SRK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srk assertion failed");

// Next-cycle implication, disabled while in reset
`define SRK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srk assertion failed");

`endif

### sv/srk_pkg.sv
package srk_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_SERVER_ADDR    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVER_PORT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRY      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HB_INTERVAL    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_INTERVAL = 3'd4;

    // Register reset values
    localparam logic [7:0]  RST_MAX_RETRY      = 8'd3;
    localparam logic [23:0] RST_HB_INTERVAL    = 24'd30000;
    localparam logic [23:0] RST_RETRY_INTERVAL = 24'd3000;
    localparam logic [31:0] RST_HB_LIMIT       = 32'd90000;

    // Protocol constants
    localparam logic [9:0] STATUS_OK = 10'd200;
    localparam logic [7:0] RETRY_SAT = 8'hFF;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_REG_RSP = 2'd2,
        REQ_HB_RSP  = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_INIT    = 3'd1,
        PH_WAIT    = 3'd2,
        PH_REG     = 3'd3,
        PH_FAIL    = 3'd4,
        PH_TIMEOUT = 3'd5
    } link_phase_t;

    typedef struct packed {
        logic [31:0] server_addr;
        logic [15:0] server_port;
        logic [7:0]  max_retry;
        logic [23:0] hb_interval;
        logic [23:0] retry_interval;
        logic [31:0] hb_limit;
    } cfg_t;

    typedef struct packed {
        link_phase_t phase;
        logic [7:0]  retry_count;
        logic [31:0] last_request_ms;
        logic [31:0] last_heartbeat_ms;
        logic [31:0] seq;
    } state_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [31:0] now_ms;
        logic [31:0] from_addr;
        logic [15:0] from_port;
        logic [9:0]  ret_code;
        logic        send_accepted;
    } item_t;

    typedef struct packed {
        logic        send_register;
        logic        send_heartbeat;
        logic [31:0] seq;
        link_phase_t phase;
        logic        dropped;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:             PH_IDLE,
        retry_count:       8'd0,
        last_request_ms:   32'd0,
        last_heartbeat_ms: 32'd0,
        seq:               32'd0
    };

endpackage

### sv/srk_cfg.sv
module srk_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [srk_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srk_pkg::CFG_DATA_W-1:0]     cfg_data,
    output srk_pkg::cfg_t                      cfg
);

    logic [31:0] server_addr_reg,    server_addr_next;
    logic [15:0] server_port_reg,    server_port_next;
    logic [7:0]  max_retry_reg,      max_retry_next;
    logic [23:0] hb_interval_reg,    hb_interval_next;
    logic [23:0] retry_interval_reg, retry_interval_next;
    logic [31:0] hb_limit_reg,       hb_limit_next;

    // Decode the write
    always_comb
    begin
        server_addr_next    = server_addr_reg;
        server_port_next    = server_port_reg;
        max_retry_next      = max_retry_reg;
        hb_interval_next    = hb_interval_reg;
        retry_interval_next = retry_interval_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                srk_pkg::CFG_SERVER_ADDR:    server_addr_next    = cfg_data;
                srk_pkg::CFG_SERVER_PORT:    server_port_next    = cfg_data[15:0];
                srk_pkg::CFG_MAX_RETRY:      max_retry_next      = cfg_data[7:0];
                srk_pkg::CFG_HB_INTERVAL:    hb_interval_next    = cfg_data[23:0];
                srk_pkg::CFG_RETRY_INTERVAL: retry_interval_next = cfg_data[23:0];
                default:                     ;
            endcase
        end
    end

    // Keep the heartbeat timeout limit in step with its two registers;
    // 24 x 8 bits never exceeds 32 bits
    assign hb_limit_next = {8'd0, hb_interval_next} * {24'd0, max_retry_next};

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_addr_reg    <= 32'd0;
            server_port_reg    <= 16'd0;
            max_retry_reg      <= srk_pkg::RST_MAX_RETRY;
            hb_interval_reg    <= srk_pkg::RST_HB_INTERVAL;
            retry_interval_reg <= srk_pkg::RST_RETRY_INTERVAL;
            hb_limit_reg       <= srk_pkg::RST_HB_LIMIT;
        end
        else
        begin
            server_addr_reg    <= server_addr_next;
            server_port_reg    <= server_port_next;
            max_retry_reg      <= max_retry_next;
            hb_interval_reg    <= hb_interval_next;
            retry_interval_reg <= retry_interval_next;
            hb_limit_reg       <= hb_limit_next;
        end
    end

    assign cfg = '{
        server_addr:    server_addr_reg,
        server_port:    server_port_reg,
        max_retry:      max_retry_reg,
        hb_interval:    hb_interval_reg,
        retry_interval: retry_interval_reg,
        hb_limit:       hb_limit_reg
    };

endmodule

### sv/srk_step.sv
module srk_step (
    input  srk_pkg::state_t   state,
    input  srk_pkg::item_t    item,
    input  srk_pkg::cfg_t     cfg,
    output srk_pkg::state_t   state_next,
    output srk_pkg::result_t  result
);

    logic [31:0] since_request;
    logic [31:0] since_heartbeat;
    logic        retry_due;
    logic        hb_due;
    logic        hb_expired;
    logic        retries_spent;
    logic        sender_ok;
    logic        send_register;
    logic        send_heartbeat;
    logic        dropped;

    // Elapsed times wrap modulo 2^32
    assign since_request   = item.now_ms - state.last_request_ms;
    assign since_heartbeat = item.now_ms - state.last_heartbeat_ms;
    assign retry_due       = since_request > {8'd0, cfg.retry_interval};
    assign hb_due          = since_request > {8'd0, cfg.hb_interval};
    assign hb_expired      = since_heartbeat > cfg.hb_limit;
    assign retries_spent   = state.retry_count > cfg.max_retry;
    assign sender_ok       = (item.from_addr == cfg.server_addr)
                          && (item.from_port == cfg.server_port);

    // Next link state
    always_comb
    begin
        state_next = state;
        case (item.kind)
            srk_pkg::REQ_START:
            begin
                state_next.phase           = srk_pkg::PH_INIT;
                state_next.retry_count     = 8'd0;
                state_next.last_request_ms = 32'd0;
            end
            srk_pkg::REQ_TICK:
            begin
                case (state.phase)
                    srk_pkg::PH_INIT:
                    begin
                        state_next.seq = state.seq + 32'd1;
                        if (item.send_accepted)
                        begin
                            state_next.phase           = srk_pkg::PH_WAIT;
                            state_next.last_request_ms = item.now_ms;
                        end
                        else
                        begin
                            state_next.phase = srk_pkg::PH_FAIL;
                        end
                    end
                    srk_pkg::PH_WAIT:
                    begin
                        if (retry_due && retries_spent)
                        begin
                            state_next.phase = srk_pkg::PH_FAIL;
                        end
                        else if (retry_due)
                        begin
                            if (state.retry_count != srk_pkg::RETRY_SAT)
                            begin
                                state_next.retry_count = state.retry_count + 8'd1;
                            end
                            state_next.seq = state.seq + 32'd1;
                            if (item.send_accepted)
                            begin
                                state_next.last_request_ms = item.now_ms;
                            end
                            else
                            begin
                                state_next.phase = srk_pkg::PH_FAIL;
                            end
                        end
                    end
                    srk_pkg::PH_REG:
                    begin
                        if (hb_due)
                        begin
                            state_next.seq = state.seq + 32'd1;
                            if (item.send_accepted)
                            begin
                                state_next.last_request_ms = item.now_ms;
                            end
                        end
                        if (hb_expired)
                        begin
                            state_next.phase = srk_pkg::PH_TIMEOUT;
                        end
                    end
                    default:
                    begin
                        // idle, failed and timed out ignore ticks
                    end
                endcase
            end
            srk_pkg::REQ_REG_RSP:
            begin
                if (sender_ok && item.ret_code == srk_pkg::STATUS_OK)
                begin
                    state_next.phase             = srk_pkg::PH_REG;
                    state_next.last_heartbeat_ms = item.now_ms;
                end
                else if (sender_ok)
                begin
                    state_next.phase = srk_pkg::PH_FAIL;
                end
            end
            srk_pkg::REQ_HB_RSP:
            begin
                if (sender_ok)
                begin
                    state_next.last_heartbeat_ms = item.now_ms;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // Request and drop flags
    always_comb
    begin
        send_register  = 1'b0;
        send_heartbeat = 1'b0;
        dropped        = 1'b0;
        case (item.kind)
            srk_pkg::REQ_TICK:
            begin
                send_register  = (state.phase == srk_pkg::PH_INIT)
                              || (state.phase == srk_pkg::PH_WAIT && retry_due
                                  && !retries_spent);
                send_heartbeat = (state.phase == srk_pkg::PH_REG) && hb_due;
            end
            srk_pkg::REQ_REG_RSP, srk_pkg::REQ_HB_RSP:
            begin
                dropped = !sender_ok;
            end
            default:
            begin
                dropped = 1'b0;
            end
        endcase
    end

    assign result = '{
        send_register:  send_register,
        send_heartbeat: send_heartbeat,
        seq:            state_next.seq,
        phase:          state_next.phase,
        dropped:        dropped
    };

endmodule

### sv/server_registration_keepalive.sv
// Client-side registration and keepalive supervisor for one server. Each
// item (start, tick, registration response, heartbeat response) produces
// exactly one result item carrying the send flags, the sequence number and
// the link state after that item. One item is taken per clock cycle unless
// out_stall holds the result: an item is registered on input, the link state
// is updated in one pass through the step logic and the result is registered
// on output. The input register also absorbs one item while a result waits
// on out_stall. Configuration writes take effect on the next cycle; the
// heartbeat timeout limit (interval times max_retry) is kept in a register
// next to them.
module server_registration_keepalive (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [srk_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srk_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic [31:0]                        now_ms,
    input  logic [31:0]                        from_addr,
    input  logic [15:0]                        from_port,
    input  logic [9:0]                         ret_code,
    input  logic                               send_accepted,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               send_register,
    output logic                               send_heartbeat,
    output logic [31:0]                        seq_out,
    output logic [2:0]                         link_state,
    output logic                               dropped
);

`include "server_registration_keepalive_macros.svh"

    srk_pkg::cfg_t    cfg;
    srk_pkg::state_t  state_reg, state_next;
    srk_pkg::item_t   item_reg, item_next;
    srk_pkg::result_t result_reg, result_next;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;
    logic             advance;

    srk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srk_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Advance the held item when the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    // Pack the incoming item
    assign item_next = '{
        kind:          srk_pkg::req_kind_t'(req_type),
        now_ms:        now_ms,
        from_addr:     from_addr,
        from_port:     from_port,
        ret_code:      ret_code,
        send_accepted: send_accepted
    };

    // Stage occupancy
    always_comb
    begin
        in_valid_next  = in_fire || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    // Control and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= srk_pkg::STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign send_register  = result_reg.send_register;
    assign send_heartbeat = result_reg.send_heartbeat;
    assign seq_out        = result_reg.seq;
    assign link_state     = result_reg.phase;
    assign dropped        = result_reg.dropped;

    // Checks
    `SRK_ASSERT_NOW(a_one_request, out_valid_reg,
        !(result_reg.send_register && result_reg.send_heartbeat))
    `SRK_ASSERT_NEXT(a_seq_step, advance,
        state_reg.seq == $past(state_reg.seq)
            + {31'd0, $past(result_next.send_register || result_next.send_heartbeat)})
    `SRK_ASSERT_NOW(a_register_phase, out_valid_reg && result_reg.send_register,
        result_reg.phase == srk_pkg::PH_WAIT || result_reg.phase == srk_pkg::PH_FAIL)
    `SRK_ASSERT_NOW(a_drop_on_response, advance && result_next.dropped,
        item_reg.kind == srk_pkg::REQ_REG_RSP || item_reg.kind == srk_pkg::REQ_HB_RSP)

endmodule
